[design/iair_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_pkg
// Shared word types and operation/status codes of the indexed array block.
// ----------------------------------------------------------------------------
package iair_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned CntW   = 7;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 2;

  localparam logic [OpW-1:0] OP_INS_AT  = 3'd0;
  localparam logic [OpW-1:0] OP_INS_FRT = 3'd1;
  localparam logic [OpW-1:0] OP_INS_BCK = 3'd2;
  localparam logic [OpW-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OpW-1:0] OP_READ    = 3'd4;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_BAD_IDX = 2'd1;
  localparam logic [StatW-1:0] ST_FULL    = 2'd2;
  localparam logic [StatW-1:0] ST_BAD_LEN = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic [IdxW-1:0]         index;
    logic [IdxW-1:0]         length;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic [CntW-1:0]         count;
    logic signed [DataW-1:0] read_value;
  } rsp_t;

endpackage

[design/iair_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_req_if
// Request channel: one operation word per valid/ready handshake.
// ----------------------------------------------------------------------------
interface iair_req_if;
  import iair_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/iair_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_rsp_if
// Response channel: status, count and read data, one word per handshake.
// ----------------------------------------------------------------------------
interface iair_rsp_if;
  import iair_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/iair_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iair_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic [iair_pkg::DataW-1:0]      wdata_i,
  input  logic                            re_i,
  input  logic [AW-1:0]                   raddr_i,
  output logic [iair_pkg::DataW-1:0]      rdata_o
);
  import iair_pkg::*;

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/iair_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_ctrl
// Operation sequencer: checks bounds, walks the shift through the store one
// entry per cycle, and holds the response word.
// ----------------------------------------------------------------------------
module iair_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  iair_req_if.sink                        req_i,
  iair_rsp_if.source                      rsp_o,
  output logic                            mem_we_o,
  output logic [AW-1:0]                   mem_waddr_o,
  output logic [iair_pkg::DataW-1:0]      mem_wdata_o,
  output logic                            mem_re_o,
  output logic [AW-1:0]                   mem_raddr_o,
  input  logic [iair_pkg::DataW-1:0]      mem_rdata_i
);
  import iair_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > IdxW) ? CW : IdxW;
  localparam logic [XW-1:0] DepthX = XW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PUT,
    S_READ,
    S_RDATA,
    S_RESP
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    left_q;
  logic [AW-1:0]    rd_addr_q;
  logic [AW-1:0]    wr_addr_q;
  logic             vld_q;
  logic             dn_q;
  logic             ins_q;
  logic [DataW-1:0] val_q;
  logic [StatW-1:0] status_q;
  logic [DataW-1:0] rdval_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q;

  logic             accept;
  logic [XW-1:0]    cnt_x;
  logic [XW-1:0]    idx_x;
  logic [XW-1:0]    len_x;
  logic [XW-1:0]    pos_x;
  logic [XW:0]      end_x;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign cnt_x = XW'(count_q);
  assign idx_x = XW'(req_i.data.index);
  assign len_x = XW'(req_i.data.length);
  assign end_x = (XW + 1)'(idx_x) + (XW + 1)'(len_x);

  always_comb begin
    case (req_i.data.op)
      OP_INS_AT:  pos_x = idx_x;
      OP_INS_FRT: pos_x = '0;
      default:    pos_x = cnt_x;
    endcase
  end

  // reads run ahead of writes in the shift direction, so no entry is read
  // in the cycle it is written
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_addr_q;
    mem_wdata_o = mem_rdata_i;
    case (state_q)
      S_MOVE: begin
        mem_re_o = (left_q != '0);
        mem_we_o = vld_q;
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = val_q;
      end
      S_READ: begin
        mem_re_o = 1'b1;
      end
      default: begin
        mem_re_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      rd_addr_q   <= '0;
      wr_addr_q   <= '0;
      vld_q       <= 1'b0;
      dn_q        <= 1'b0;
      ins_q       <= 1'b0;
      val_q       <= '0;
      status_q    <= ST_OK;
      rdval_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && (state_q != S_RESP)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            rdval_q  <= '0;
            vld_q    <= 1'b0;
            val_q    <= req_i.data.value;
            case (req_i.data.op)
              OP_INS_AT, OP_INS_FRT, OP_INS_BCK: begin
                if (pos_x > cnt_x) begin
                  status_q <= ST_BAD_IDX;
                  state_q  <= S_RESP;
                end else if (cnt_x >= DepthX) begin
                  status_q <= ST_FULL;
                  state_q  <= S_RESP;
                end else begin
                  status_q  <= ST_OK;
                  left_q    <= CW'(cnt_x - pos_x);
                  rd_addr_q <= AW'(cnt_x - XW'(1));
                  wr_addr_q <= AW'(cnt_x);
                  dn_q      <= 1'b1;
                  ins_q     <= 1'b1;
                  count_q   <= CW'(count_q + CW'(1));
                  state_q   <= S_MOVE;
                end
              end
              OP_REMOVE: begin
                if (idx_x >= cnt_x) begin
                  status_q <= ST_BAD_IDX;
                  state_q  <= S_RESP;
                end else if (end_x > (XW + 1)'(cnt_x)) begin
                  status_q <= ST_BAD_LEN;
                  state_q  <= S_RESP;
                end else if (len_x != '0) begin
                  status_q  <= ST_OK;
                  left_q    <= CW'((XW + 1)'(cnt_x) - end_x);
                  rd_addr_q <= AW'(end_x);
                  wr_addr_q <= AW'(idx_x);
                  dn_q      <= 1'b0;
                  ins_q     <= 1'b0;
                  count_q   <= CW'(cnt_x - len_x);
                  state_q   <= S_MOVE;
                end else begin
                  status_q <= ST_OK;
                  state_q  <= S_RESP;
                end
              end
              OP_READ: begin
                if (idx_x >= cnt_x) begin
                  status_q <= ST_BAD_IDX;
                  state_q  <= S_RESP;
                end else begin
                  status_q  <= ST_OK;
                  rd_addr_q <= AW'(idx_x);
                  state_q   <= S_READ;
                end
              end
              default: begin
                status_q <= ST_OK;
                state_q  <= S_RESP;
              end
            endcase
          end
        end
        S_MOVE: begin
          vld_q <= (left_q != '0);
          if (left_q != '0) begin
            left_q    <= CW'(left_q - CW'(1));
            rd_addr_q <= dn_q ? AW'(rd_addr_q - AW'(1)) : AW'(rd_addr_q + AW'(1));
          end
          if (vld_q) begin
            wr_addr_q <= dn_q ? AW'(wr_addr_q - AW'(1)) : AW'(wr_addr_q + AW'(1));
          end
          if (left_q == '0) begin
            state_q <= ins_q ? S_PUT : S_RESP;
          end
        end
        S_PUT: begin
          state_q <= S_RESP;
        end
        S_READ: begin
          state_q <= S_RDATA;
        end
        S_RDATA: begin
          rdval_q <= mem_rdata_i;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q      <= 1'b1;
            rsp_q.status     <= status_q;
            rsp_q.count      <= CntW'(count_q);
            rsp_q.read_value <= rdval_q;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/indexed_array_insert_remove.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_insert_remove
// Ordered store of up to DEPTH signed 32-bit entries with insert, remove
// range and read operations.
//
// req_i takes one operation word (op, index, length, value) per valid/ready
// handshake; rsp_o returns one word (status, count, read_value) for each.
// Operations run one at a time: req_i.ready is high only while the
// sequencer is idle. The response sits in an output register, so a new
// request is taken while the previous response still waits on rsp_o.
// A rejected or empty operation goes straight to the response step, a read
// passes through the registered read port first, and an insert or a remove
// shifts the entries behind its position one entry per cycle through the
// single-port-write store before the response.
// Reset empties the array at once; entry contents are not cleared and are
// never visible before being written. A stalled rsp_o holds its word and
// holds the sequencer in its last step, so no response is dropped.
// ----------------------------------------------------------------------------
module indexed_array_insert_remove #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iair_req_if.sink    req_i,
  iair_rsp_if.source  rsp_o
);
  import iair_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [DataW-1:0] mem_rdata;

  iair_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  iair_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[design/iair_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iair_chk
// Port-level checks on the indexed array block, bound to its top level.
// ----------------------------------------------------------------------------
module iair_chk #(
  parameter int unsigned DEPTH = 64
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input iair_pkg::rsp_t  rsp_data_i
);
  import iair_pkg::*;

  logic [1:0] pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= 2'(pending_q + 2'(req_valid_i && req_ready_i)
                   - 2'(rsp_valid_i && rsp_ready_i));
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response word changed while stalled");

  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != '0)
    else $error("response without an outstanding request");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status != ST_OK |-> rsp_data_i.read_value == '0)
    else $error("read data not zero on a failed operation");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.status == ST_FULL |-> rsp_data_i.count == CntW'(DEPTH))
    else $error("full status with count below depth");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (DEPTH > 127) || (32'(rsp_data_i.count) <= DEPTH))
    else $error("count above depth");

endmodule

bind indexed_array_insert_remove iair_chk #(
  .DEPTH (DEPTH)
) u_iair_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

[bench/tb_indexed_array_insert_remove.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_insert_remove
// Self-checking bench for the indexed array block. A directed burst covers
// empty-array errors, value extremes, bad index and bad length removes,
// unused op codes and tail removal. Random traffic then alternates between
// filling the array up to full and draining it, with some malformed words
// mixed in. Each accepted request updates an array model kept in a small
// scoreboard class. Every response is checked field by field, in order; the
// random traffic runs in four phases: none, source idling, sink stalling, both.
// ----------------------------------------------------------------------------
module tb_indexed_array_insert_remove;
  import iair_pkg::*;

  localparam int unsigned DEPTH         = 64;
  localparam int unsigned ItemsPerPhase = 262;
  localparam int unsigned NumPhases     = 4;

  class array_scoreboard;
    logic signed [DataW-1:0] entries [DEPTH];
    int unsigned             held;
    rsp_t                    pending_q [$];
    int unsigned             errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void note_request(req_t w);
      rsp_t        r;
      int unsigned pos;
      int unsigned i;
      r.status     = ST_OK;
      r.read_value = '0;
      case (w.op)
        OP_INS_AT, OP_INS_FRT, OP_INS_BCK: begin
          pos = (w.op == OP_INS_AT) ? w.index : (w.op == OP_INS_FRT) ? 0 : held;
          if (pos > held) begin
            r.status = ST_BAD_IDX;
          end else if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = held; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = w.value;
            held++;
          end
        end
        OP_REMOVE: begin
          if (w.index >= held) begin
            r.status = ST_BAD_IDX;
          end else if (w.length > held - w.index) begin
            r.status = ST_BAD_LEN;
          end else if (w.length != 0) begin
            for (i = w.index; i + w.length < held; i++) entries[i] = entries[i + w.length];
            held -= w.length;
          end
        end
        OP_READ: begin
          if (w.index >= held) r.status = ST_BAD_IDX;
          else r.read_value = entries[w.index];
        end
        default: ;
      endcase
      r.count = CntW'(held);
      pending_q.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word status=%0d count=%0d read_value=%0d",
                 $time, got.status, got.count, got.read_value);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %0d actual %0d",
                 $time, want.read_value, got.read_value);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  iair_req_if req_if ();
  iair_rsp_if rsp_if ();

  indexed_array_insert_remove #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  array_scoreboard sb;
  int unsigned     src_idle_pct;
  int unsigned     sink_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_word(input req_t w);
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(w);
  endtask

  task automatic send_op(input logic [OpW-1:0] op, input logic [IdxW-1:0] index,
                         input logic [IdxW-1:0] length, input logic signed [DataW-1:0] value);
    req_t w;
    w.op     = op;
    w.index  = index;
    w.length = length;
    w.value  = value;
    send_word(w);
  endtask

  function automatic req_t random_word(input int unsigned held, input bit filling);
    req_t        w;
    int unsigned pick;
    int unsigned room;
    w.op     = OP_READ;
    w.index  = '0;
    w.length = '0;
    w.value  = $urandom();
    pick     = $urandom_range(99);
    if (pick < 6) begin
      // malformed or unused word
      w.op     = OpW'($urandom_range(2**OpW - 1));
      w.index  = IdxW'($urandom());
      w.length = IdxW'($urandom());
    end else if (pick < (filling ? 72 : 36)) begin
      case ($urandom_range(2))
        0: begin
          w.op    = OP_INS_AT;
          w.index = IdxW'($urandom_range(held));
        end
        1: begin
          w.op    = OP_INS_FRT;
          w.index = IdxW'($urandom());
        end
        default: begin
          w.op    = OP_INS_BCK;
          w.index = IdxW'($urandom());
        end
      endcase
    end else if (pick < (filling ? 84 : 80)) begin
      w.op = OP_REMOVE;
      if (held != 0) begin
        w.index = IdxW'($urandom_range(held - 1));
        room    = held - w.index;
        if (!filling && $urandom_range(3) == 0) w.length = IdxW'($urandom_range(room));
        else w.length = IdxW'($urandom_range(room < 4 ? room : 4));
      end
    end else begin
      if (held != 0) w.index = IdxW'($urandom_range(held - 1));
    end
    return w;
  endfunction

  initial begin
    bit   filling;
    req_t w;
    sb             = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty array errors
    send_op(OP_READ, 0, 0, 32'sd5);
    send_op(OP_REMOVE, 0, 0, 32'sd0);
    send_op(OP_INS_AT, 1, 0, 32'sd9);
    // value extremes, front and back ignore index
    send_op(OP_INS_BCK, 127, 0, 32'sh7fffffff);
    send_op(OP_INS_FRT, 127, 0, 32'sh80000000);
    send_op(OP_INS_AT, 1, 0, 32'sd0);
    send_op(OP_INS_AT, 3, 0, -32'sd1);
    for (int k = 0; k < 4; k++) send_op(OP_READ, IdxW'(k), 0, 32'sd0);
    send_op(OP_READ, 4, 0, 32'sd0);
    send_op(OP_READ, 127, 127, 32'sd0);
    // empty remove, bad lengths, bad index
    send_op(OP_REMOVE, 1, 0, 32'sd1);
    send_op(OP_REMOVE, 1, 4, 32'sd1);
    send_op(OP_REMOVE, 1, 127, 32'sd1);
    send_op(OP_REMOVE, 127, 1, 32'sd1);
    for (int c = OP_READ + 1; c < 2**OpW; c++) begin
      send_op(OpW'(c), IdxW'($urandom()), IdxW'($urandom()), $urandom());
    end
    // tail remove then whole array
    send_op(OP_REMOVE, 2, 2, 32'sd0);
    send_op(OP_READ, 1, 0, 32'sd0);
    send_op(OP_REMOVE, 0, 2, 32'sd0);
    send_op(OP_INS_AT, 127, 0, 32'sd3);

    filling = 1'b1;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 63;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 63;
        end
        default: begin
          src_idle_pct   = 27;
          sink_stall_pct = 27;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        w = random_word(sb.held, filling);
        send_word(w);
        if (filling && sb.held == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        else if (!filling && sb.held <= 2) filling = 1'b1;
      end
    end
    req_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
